@@ rtl/morton_spatial_hash_neighbor_lookup_assert.svh @@
// Assertion macros for the spatial hash lookup block.
// Depends on nothing; included by the files that carry assertions.
`ifndef MORTON_SPATIAL_HASH_NEIGHBOR_LOOKUP_ASSERT_SVH
`define MORTON_SPATIAL_HASH_NEIGHBOR_LOOKUP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MSHNL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSHNL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mshnl_pkg.sv @@
// Shared types and constants for the spatial hash neighbour lookup block.
// Depends on nothing; imported by the top level.
`default_nettype none

package mshnl_pkg;

   localparam int HASH_BITS_DEF  = 18;
   localparam int INDEX_BITS_DEF = 20;

   localparam int CMD_W   = 2;
   localparam int COORD_W = 21;
   localparam int IDX_W   = 20;
   localparam int CNT_W   = 5;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   // Each axis steps through offsets 0, 1 and 2 around the cell minus one.
   localparam logic [1:0] OFF_LAST = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
      logic [COORD_W-1:0] cell_z;
      logic [IDX_W-1:0]   entry_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] found_index;
      logic             hit;
      logic             last;
      logic [CNT_W-1:0] hit_count;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/morton_spatial_hash_neighbor_lookup.sv @@
// Spatial hash grid with Morton-interleaved keys and a 27-neighbour query.
// An insert is written to the table as it is accepted. A query holds the block through one read of the
// single table port per neighbour cell, a drain of the last read and the final result, and
// longer if the result side stalls. Clear sweeps the table one entry a cycle over all
// 2^HASH_BITS entries (262144 by default). Reset starts that same sweep, so the block
// accepts its first transfer only once the sweep has finished.
`default_nettype none

`include "morton_spatial_hash_neighbor_lookup_assert.svh"

module morton_spatial_hash_neighbor_lookup
   import mshnl_pkg::*;
#(
   parameter int HASH_BITS  = HASH_BITS_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   // Only the low bits of each axis reach the key, so the neighbour arithmetic is kept
   // to that width; wrapping modulo 2^21 agrees with wrapping at this narrower width.
   localparam int AXIS_BITS   = (HASH_BITS + 2) / 3;
   localparam int TABLE_DEPTH = 1 << HASH_BITS;
   localparam int ENTRY_W     = INDEX_BITS + 1;

   // Sequencer state.
   state_type state_ff, state_in;

   // Table: one entry per key, valid flag in the top bit and the particle index below it.
   logic [ENTRY_W-1:0]   cell_mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0]   rd_data_ff;
   logic                 rd_vld_ff;
   logic                 wr_en;
   logic [HASH_BITS-1:0] wr_addr;
   logic [ENTRY_W-1:0]   wr_data;

   logic [HASH_BITS-1:0] clr_addr_ff;
   logic [HASH_BITS-1:0] prev_key_ff;
   logic                 prev_vld_ff;

   // Query scan registers: the cell minus one on each axis, and the three offsets.
   logic [AXIS_BITS-1:0] base_x_ff, base_y_ff, base_z_ff;
   logic [1:0]           off_x_ff, off_y_ff, off_z_ff;
   logic                 scan_more_ff;

   // A hit is held back until the next one is found, since only the final hit carries
   // the last flag and the count.
   logic [INDEX_BITS-1:0] pend_idx_ff;
   logic                  pend_vld_ff;
   logic [CNT_W-1:0]      cnt_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // Shared key unit: the request cell while idle, the current neighbour while scanning.
   logic [AXIS_BITS-1:0] key_x, key_y, key_z;
   logic [HASH_BITS-1:0] hash_key;

   logic req_fire, out_full, rd_hit, stall, issue, last_issue, scan_done;
   logic push_mid, push_final, do_insert;

   always_comb begin
      if (state_ff == ST_IDLE) begin
         key_x = req_data.cell_x[AXIS_BITS-1:0];
         key_y = req_data.cell_y[AXIS_BITS-1:0];
         key_z = req_data.cell_z[AXIS_BITS-1:0];
      end else begin
         key_x = base_x_ff + AXIS_BITS'(off_x_ff);
         key_y = base_y_ff + AXIS_BITS'(off_y_ff);
         key_z = base_z_ff + AXIS_BITS'(off_z_ff);
      end
   end

   // Morton interleave: key bit b takes bit b/3 of axis b mod 3, with x at bit 0.
   for (genvar gb = 0; gb < HASH_BITS; gb++) begin : g_key
      if (gb % 3 == 0) begin : g_x
         assign hash_key[gb] = key_x[gb / 3];
      end else if (gb % 3 == 1) begin : g_y
         assign hash_key[gb] = key_y[gb / 3];
      end else begin : g_z
         assign hash_key[gb] = key_z[gb / 3];
      end
   end

   // Handshake and scan control terms.
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid & req_ready;
   assign out_full   = rsp_valid_ff & ~rsp_ready;
   assign rd_hit     = rd_vld_ff & rd_data_ff[INDEX_BITS];
   // A new hit can only be taken when the held one has somewhere to go.
   assign stall      = rd_hit & pend_vld_ff & out_full;
   assign last_issue = (off_x_ff == OFF_LAST) & (off_y_ff == OFF_LAST) & (off_z_ff == OFF_LAST);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == {HASH_BITS{1'b1}}) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire && req_data.command == CMD_CLEAR) state_in = ST_CLEAR;
            else if (req_fire && req_data.command == CMD_QUERY) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            if (!out_full) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      issue      = 1'b0;
      scan_done  = 1'b0;
      push_mid   = 1'b0;
      push_final = 1'b0;
      do_insert  = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = hash_key;
      wr_data    = {1'b1, INDEX_BITS'(req_data.entry_index)};
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = '0;
         end
         ST_IDLE: begin
            // Sorted input: only the first entry of each key is stored.
            do_insert = req_fire && req_data.command == CMD_INSERT &&
                        (!prev_vld_ff || hash_key != prev_key_ff);
            wr_en     = do_insert;
         end
         ST_SCAN: begin
            issue     = scan_more_ff & ~stall;
            scan_done = ~scan_more_ff & ~stall;
            push_mid  = ~stall & rd_hit & pend_vld_ff;
         end
         ST_FINAL: begin
            push_final = ~out_full;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= cell_mem[hash_key];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         prev_key_ff  <= '0;
         prev_vld_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         scan_more_ff <= 1'b0;
         pend_vld_ff  <= 1'b0;
         cnt_ff       <= '0;
         off_x_ff     <= '0;
         off_y_ff     <= '0;
         off_z_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         // The sweep counter wraps back to zero on the last entry, ready for the next clear.
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (req_fire && req_data.command == CMD_CLEAR) begin
            prev_vld_ff <= 1'b0;
         end
         if (do_insert) begin
            prev_key_ff <= hash_key;
            prev_vld_ff <= 1'b1;
         end

         if (req_fire && req_data.command == CMD_QUERY) begin
            scan_more_ff <= 1'b1;
            rd_vld_ff    <= 1'b0;
            pend_vld_ff  <= 1'b0;
            cnt_ff       <= '0;
            off_x_ff     <= '0;
            off_y_ff     <= '0;
            off_z_ff     <= '0;
         end else if (state_ff == ST_SCAN && !stall) begin
            rd_vld_ff <= issue;
            if (rd_hit) begin
               pend_vld_ff <= 1'b1;
               cnt_ff      <= cnt_ff + 1'b1;
            end
            if (issue) begin
               // z runs innermost, x outermost.
               if (last_issue) begin
                  scan_more_ff <= 1'b0;
               end
               if (off_z_ff != OFF_LAST) begin
                  off_z_ff <= off_z_ff + 1'b1;
               end else begin
                  off_z_ff <= '0;
                  if (off_y_ff != OFF_LAST) begin
                     off_y_ff <= off_y_ff + 1'b1;
                  end else begin
                     off_y_ff <= '0;
                     off_x_ff <= off_x_ff + 1'b1;
                  end
               end
            end
         end

         // Output register: loaded only when empty or being emptied by this transfer.
         if (push_mid || push_final) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire && req_data.command == CMD_QUERY) begin
         base_x_ff <= req_data.cell_x[AXIS_BITS-1:0] - AXIS_BITS'(1);
         base_y_ff <= req_data.cell_y[AXIS_BITS-1:0] - AXIS_BITS'(1);
         base_z_ff <= req_data.cell_z[AXIS_BITS-1:0] - AXIS_BITS'(1);
      end
      if (state_ff == ST_SCAN && !stall && rd_hit) begin
         pend_idx_ff <= rd_data_ff[INDEX_BITS-1:0];
      end
      if (push_mid) begin
         rsp_data_ff.found_index <= IDX_W'(pend_idx_ff);
         rsp_data_ff.hit         <= 1'b1;
         rsp_data_ff.last        <= 1'b0;
         rsp_data_ff.hit_count   <= '0;
      end else if (push_final) begin
         // With no hits this is the single empty result.
         rsp_data_ff.found_index <= pend_vld_ff ? IDX_W'(pend_idx_ff) : '0;
         rsp_data_ff.hit         <= pend_vld_ff;
         rsp_data_ff.last        <= 1'b1;
         rsp_data_ff.hit_count   <= cnt_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MSHNL_ASSERT_NOW(a_no_overwrite, clock, reset, push_mid || push_final, !out_full, "result register overwritten while stalled")
   `MSHNL_ASSERT_NOW(a_mid_result_form, clock, reset, rsp_valid_ff && !rsp_data_ff.last, rsp_data_ff.hit && rsp_data_ff.hit_count == '0, "intermediate result malformed")
   `MSHNL_ASSERT_NOW(a_count_range, clock, reset, state_ff == ST_SCAN || state_ff == ST_FINAL, cnt_ff <= CNT_W'(27), "hit count beyond neighbour count")
   `MSHNL_ASSERT_NOW(a_no_write_in_scan, clock, reset, state_ff == ST_SCAN || state_ff == ST_FINAL, !wr_en, "table written during a query")
   `MSHNL_ASSERT_NEXT(a_stall_holds_read, clock, reset, state_ff == ST_SCAN && stall, $stable(rd_data_ff) && rd_vld_ff, "read data lost during stall")

endmodule

`default_nettype wire
